FILE: sv/chr_pkg.sv
// ============================================================================
// chr_pkg
// Shared types, constants and lookup functions of the challenge response hash.
// ============================================================================
package chr_pkg;

    localparam int MAX_CHALLENGE_BYTES = 64;
    localparam int KEY_LEN             = 16;
    localparam logic [30:0] MOD31      = 31'h7FFF_FFFF;
    localparam logic [27:0] MIX_MULT   = 28'hE79_A9C1;
    localparam logic [7:0]  PAD_CHAR   = 8'h30;
    localparam logic [7:0]  MD5_END    = 8'h80;

    localparam logic [1:0] CFG_PID_FIRST = 2'd0;
    localparam logic [1:0] CFG_PID_LAST  = 2'd1;
    localparam logic [1:0] CFG_PID_LEN   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_MD5_INIT, S_FETCH, S_CAPT, S_ROUND, S_BLK_END,
        S_MIX_INIT, S_MFETCH, S_MCAPT,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10,
        S_FIN, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_MUL_C0, OP_RED_X, OP_MUL_M0, OP_ADD_M1, OP_RED_T,
        OP_RED_C1T, OP_MUL_M2, OP_ADD_M3, OP_RED_HI, OP_ACC_LO, OP_FINAL
    } t_mop;

    typedef struct packed {
        logic  load;
        logic  md5_init;
        logic  fetch;
        logic  capt;
        logic  mix;
        logic  round;
        logic  blk_end;
        logic  mix_init;
        t_mop  op;
        logic  emit_adv;
    } t_cmd;

    typedef struct packed {
        logic blk_full;
        logic md5_done;
        logic pair_full;
        logic mix_done;
        logic rnd_last;
        logic dig_last;
    } t_stat;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [3:0] i);
        logic [4:0] s;
        unique case (i)
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] key_byte(input logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd0:  c = 8'h43; 4'd1:  c = 8'h46; 4'd2:  c = 8'h48; 4'd3:  c = 8'h55;
            4'd4:  c = 8'h52; 4'd5:  c = 8'h24; 4'd6:  c = 8'h35; 4'd7:  c = 8'h32;
            4'd8:  c = 8'h55; 4'd9:  c = 8'h5F; 4'd10: c = 8'h7B; 4'd11: c = 8'h56;
            4'd12: c = 8'h49; 4'd13: c = 8'h58; 4'd14: c = 8'h35; default: c = 8'h54;
        endcase
        return c;
    endfunction

    // x mod (2^31 - 1) by two end-around folds and one subtract
    function automatic logic [30:0] mod31(input logic [63:0] x);
        logic [33:0] s1;
        logic [31:0] s2;
        s1 = 34'(x[30:0]) + 34'(x[63:31]);
        s2 = 32'(s1[30:0]) + 32'(s1[33:31]);
        if (s2 >= 32'(MOD31)) begin
            s2 = s2 - 32'(MOD31);
        end
        return s2[30:0];
    endfunction

endpackage

FILE: sv/chr_ram.sv
// ============================================================================
// chr_ram
// Generic single write, single read RAM with registered read data.
// ============================================================================
module chr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/chr_ctrl.sv
// ============================================================================
// chr_ctrl
// Sequencer: load, MD5 blocks, modular mixing per word pair, hex emit.
// ============================================================================
module chr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_is_last,
    input  logic           i_ready,
    input  chr_pkg::t_stat i_stat,
    output chr_pkg::t_cmd  o_cmd,
    output logic           o_ready,
    output logic           o_valid
);

    chr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.op = chr_pkg::OP_NONE;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            chr_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_is_last) n_state = chr_pkg::S_MD5_INIT;
                end
            end
            chr_pkg::S_MD5_INIT: begin
                o_cmd.md5_init = 1'b1;
                n_state = chr_pkg::S_FETCH;
            end
            chr_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = chr_pkg::S_CAPT;
            end
            chr_pkg::S_CAPT: begin
                o_cmd.capt = 1'b1;
                n_state = i_stat.blk_full ? chr_pkg::S_ROUND : chr_pkg::S_FETCH;
            end
            chr_pkg::S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_stat.rnd_last) n_state = chr_pkg::S_BLK_END;
            end
            chr_pkg::S_BLK_END: begin
                o_cmd.blk_end = 1'b1;
                n_state = i_stat.md5_done ? chr_pkg::S_MIX_INIT : chr_pkg::S_FETCH;
            end
            chr_pkg::S_MIX_INIT: begin
                o_cmd.mix_init = 1'b1;
                n_state = chr_pkg::S_MFETCH;
            end
            chr_pkg::S_MFETCH: begin
                o_cmd.fetch = 1'b1;
                o_cmd.mix   = 1'b1;
                n_state = chr_pkg::S_MCAPT;
            end
            chr_pkg::S_MCAPT: begin
                o_cmd.capt = 1'b1;
                o_cmd.mix  = 1'b1;
                n_state = i_stat.pair_full ? chr_pkg::S_M1 : chr_pkg::S_MFETCH;
            end
            chr_pkg::S_M1:  begin o_cmd.op = chr_pkg::OP_MUL_C0;  n_state = chr_pkg::S_M2;  end
            chr_pkg::S_M2:  begin o_cmd.op = chr_pkg::OP_RED_X;   n_state = chr_pkg::S_M3;  end
            chr_pkg::S_M3:  begin o_cmd.op = chr_pkg::OP_MUL_M0;  n_state = chr_pkg::S_M4;  end
            chr_pkg::S_M4:  begin o_cmd.op = chr_pkg::OP_ADD_M1;  n_state = chr_pkg::S_M5;  end
            chr_pkg::S_M5:  begin o_cmd.op = chr_pkg::OP_RED_T;   n_state = chr_pkg::S_M6;  end
            chr_pkg::S_M6:  begin o_cmd.op = chr_pkg::OP_RED_C1T; n_state = chr_pkg::S_M7;  end
            chr_pkg::S_M7:  begin o_cmd.op = chr_pkg::OP_MUL_M2;  n_state = chr_pkg::S_M8;  end
            chr_pkg::S_M8:  begin o_cmd.op = chr_pkg::OP_ADD_M3;  n_state = chr_pkg::S_M9;  end
            chr_pkg::S_M9:  begin o_cmd.op = chr_pkg::OP_RED_HI;  n_state = chr_pkg::S_M10; end
            chr_pkg::S_M10: begin
                o_cmd.op = chr_pkg::OP_ACC_LO;
                n_state = i_stat.mix_done ? chr_pkg::S_FIN : chr_pkg::S_MFETCH;
            end
            chr_pkg::S_FIN: begin
                o_cmd.op = chr_pkg::OP_FINAL;
                n_state = chr_pkg::S_EMIT;
            end
            chr_pkg::S_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    o_cmd.emit_adv = 1'b1;
                    if (i_stat.dig_last) n_state = chr_pkg::S_IDLE;
                end
            end
            default: n_state = chr_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: sv/chr_dp.sv
// ============================================================================
// chr_dp
// Datapath: challenge buffer, MD5 round unit, mod 2^31-1 mixer, hex encoder.
// ============================================================================
module chr_dp #(
    parameter int MAX_CHALLENGE_BYTES = chr_pkg::MAX_CHALLENGE_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  chr_pkg::t_cmd  i_cmd,
    output chr_pkg::t_stat o_stat,
    input  logic [7:0]     i_challenge_byte,
    input  logic           i_cfg_wr_en,
    input  logic [1:0]     i_cfg_index,
    input  logic [63:0]    i_cfg_wdata,
    output logic [6:0]     o_hex_char,
    output logic           o_last_char,
    output logic           o_too_long
);

    localparam int AW = (MAX_CHALLENGE_BYTES > 1) ? $clog2(MAX_CHALLENGE_BYTES) : 1;
    localparam int CW = $clog2(MAX_CHALLENGE_BYTES + 1);
    localparam int PW = $clog2(MAX_CHALLENGE_BYTES + 89);

    logic [63:0]   r_pid_first, r_pid_last;
    logic [4:0]    r_pid_len;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [PW-1:0] r_pos;
    logic [31:0]   r_w [16];
    logic [31:0]   r_a, r_b, r_c, r_d;
    logic [31:0]   r_h [4];
    logic [5:0]    r_rnd;
    logic [63:0]   r_p;
    logic [30:0]   r_x, r_t, r_hi;
    logic [39:0]   r_lo;
    logic [4:0]    r_dig;

    logic [7:0]    ram_rdata;
    logic [PW-1:0] n_ext, lh, tot, mlen, key_off, pid_off;
    logic [4:0]    plen;
    logic [63:0]   len_bits, pid_src;
    logic [7:0]    md5_byte, mix_byte, cap_byte;
    logic [3:0]    wi;
    logic [1:0]    rq;
    logic [31:0]   f, kk, sum, rot, wg;
    logic [3:0]    g;
    logic [4:0]    s;
    logic [30:0]   m0, m1, m2, m3;
    logic [31:0]   ow;
    logic [7:0]    ob;
    logic [3:0]    nib;

    chr_ram #(.WIDTH(8), .DEPTH(MAX_CHALLENGE_BYTES)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load && (r_count < CW'(MAX_CHALLENGE_BYTES))),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_challenge_byte),
        .i_raddr(r_pos[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_ext    = PW'(r_count);
        lh       = n_ext + PW'(chr_pkg::KEY_LEN);
        tot      = PW'({(lh + PW'(8)) >> 6, 6'd0}) + PW'(64);
        plen     = (r_pid_len > 5'd16) ? 5'd16 : r_pid_len;
        mlen     = PW'({((n_ext + PW'(plen)) >> 3), 3'd0}) + PW'(8);
        len_bits = 64'(lh) << 3;
        key_off  = r_pos - n_ext;
        pid_off  = r_pos - n_ext;
        pid_src  = pid_off[3] ? r_pid_last : r_pid_first;

        if (r_pos < n_ext) begin
            md5_byte = ram_rdata;
        end else if (r_pos < lh) begin
            md5_byte = chr_pkg::key_byte(key_off[3:0]);
        end else if (r_pos == lh) begin
            md5_byte = chr_pkg::MD5_END;
        end else if (r_pos >= tot - PW'(8)) begin
            md5_byte = len_bits[8*r_pos[2:0] +: 8];
        end else begin
            md5_byte = 8'h00;
        end

        if (r_pos < n_ext) begin
            mix_byte = ram_rdata;
        end else if (r_pos < n_ext + PW'(plen)) begin
            mix_byte = pid_src[8*pid_off[2:0] +: 8];
        end else begin
            mix_byte = chr_pkg::PAD_CHAR;
        end

        cap_byte = i_cmd.mix ? mix_byte : md5_byte;
        wi       = i_cmd.mix ? {3'd0, r_pos[2]} : r_pos[5:2];

        rq = r_rnd[5:4];
        unique case (rq)
            2'd0: begin f = (r_b & r_c) | (~r_b & r_d); g = r_rnd[3:0]; end
            2'd1: begin f = (r_d & r_b) | (~r_d & r_c); g = 4'(4'd5 * r_rnd[3:0] + 4'd1); end
            2'd2: begin f = r_b ^ r_c ^ r_d;            g = 4'(4'd3 * r_rnd[3:0] + 4'd5); end
            default: begin f = r_c ^ (r_b | ~r_d);      g = 4'(4'd7 * r_rnd[3:0]); end
        endcase
        kk  = chr_pkg::md5_k(r_rnd);
        s   = chr_pkg::md5_s({rq, r_rnd[1:0]});
        wg  = r_w[g];
        sum = r_a + f + kk + wg;
        rot = (sum << s) | (sum >> (6'd32 - 6'(s)));

        m0 = r_h[0][30:0];
        m1 = r_h[1][30:0];
        m2 = r_h[2][30:0];
        m3 = r_h[3][30:0];

        ow  = r_h[r_dig[4:3]] ^ (r_dig[3] ? 32'(r_lo) : 32'(r_hi));
        ob  = ow[8*r_dig[2:1] +: 8];
        nib = r_dig[0] ? ob[3:0] : ob[7:4];
        o_hex_char  = (nib < 4'd10) ? 7'(8'h30 + 8'(nib)) : 7'(8'h57 + 8'(nib));
        o_last_char = (r_dig == 5'd31);
        o_too_long  = r_ovf;

        o_stat.blk_full  = (r_pos[5:0] == 6'd63);
        o_stat.md5_done  = (r_pos == tot);
        o_stat.pair_full = (r_pos[2:0] == 3'd7);
        o_stat.mix_done  = (r_pos == mlen);
        o_stat.rnd_last  = (r_rnd == 6'd63);
        o_stat.dig_last  = (r_dig == 5'd31);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid_first <= '0;
            r_pid_last  <= '0;
            r_pid_len   <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_hi        <= '0;
            r_lo        <= '0;
            r_dig       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    chr_pkg::CFG_PID_FIRST: r_pid_first <= i_cfg_wdata;
                    chr_pkg::CFG_PID_LAST:  r_pid_last  <= i_cfg_wdata;
                    chr_pkg::CFG_PID_LEN:   r_pid_len   <= i_cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (r_count < CW'(MAX_CHALLENGE_BYTES)) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.mix_init) begin
                r_hi <= '0;
                r_lo <= '0;
            end
            unique case (i_cmd.op)
                chr_pkg::OP_RED_HI: r_hi <= chr_pkg::mod31(r_p);
                chr_pkg::OP_ACC_LO: r_lo <= r_lo + 40'(r_hi) + 40'(r_t);
                chr_pkg::OP_FINAL: begin
                    r_hi <= chr_pkg::mod31(64'(r_hi) + 64'(m1));
                    r_lo <= 40'(chr_pkg::mod31(64'(r_lo) + 64'(m3)));
                end
                default: ;
            endcase
            if (i_cmd.emit_adv) begin
                r_dig <= r_dig + 5'd1;
                if (r_dig == 5'd31) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.md5_init || i_cmd.mix_init) begin
            r_pos <= '0;
            r_rnd <= '0;
        end
        if (i_cmd.md5_init) begin
            r_h[0] <= 32'h67452301; r_a <= 32'h67452301;
            r_h[1] <= 32'hefcdab89; r_b <= 32'hefcdab89;
            r_h[2] <= 32'h98badcfe; r_c <= 32'h98badcfe;
            r_h[3] <= 32'h10325476; r_d <= 32'h10325476;
        end
        if (i_cmd.capt) begin
            r_w[wi][8*r_pos[1:0] +: 8] <= cap_byte;
            r_pos <= r_pos + PW'(1);
        end
        if (i_cmd.round) begin
            r_a   <= r_d;
            r_d   <= r_c;
            r_c   <= r_b;
            r_b   <= r_b + rot;
            r_rnd <= r_rnd + 6'd1;
        end
        if (i_cmd.blk_end) begin
            r_h[0] <= r_h[0] + r_a; r_a <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b; r_b <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c; r_c <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d; r_d <= r_h[3] + r_d;
        end
        unique case (i_cmd.op)
            chr_pkg::OP_MUL_C0:  r_p <= 64'(chr_pkg::MIX_MULT) * 64'(r_w[0]);
            chr_pkg::OP_RED_X:   r_x <= chr_pkg::mod31(r_p);
            chr_pkg::OP_MUL_M0:  r_p <= 64'(m0) * 64'(32'(r_x) + 32'(r_hi));
            chr_pkg::OP_ADD_M1:  r_p <= r_p + 64'(m1);
            chr_pkg::OP_RED_T:   r_t <= chr_pkg::mod31(r_p);
            chr_pkg::OP_RED_C1T: r_x <= chr_pkg::mod31(64'(r_w[1]) + 64'(r_t));
            chr_pkg::OP_MUL_M2:  r_p <= 64'(m2) * 64'(r_x);
            chr_pkg::OP_ADD_M3:  r_p <= r_p + 64'(m3);
            default: ;
        endcase
    end

endmodule

FILE: sv/challenge_response_hash_top.sv
// ============================================================================
// challenge_response_hash_top
// Challenge response engine: MD5 of challenge and key, mod 2^31-1 mixing.
// ============================================================================
// Input channel: one challenge byte per transfer, is_last marks the final one.
// Non-final bytes are taken back to back. After the final byte the input
// stalls (ready low) while the engine works: each MD5 block fetches its
// bytes from the challenge buffer, each in a fetch and a capture state,
// and then runs its rounds at one round per cycle; each 8-byte word pair
// of the mixing input is fetched the same way and then passes through the
// multiply and mod 2^31-1 reduce steps. The run time is set mainly by the
// MD5 rounds and the buffer read port.
// Output channel: 32 hex digit transfers, last_char on the final one; a
// stalled receiver simply holds the current digit. Input reopens after the
// last digit transfer. Bytes beyond the buffer depth are dropped and
// too_long is raised on every digit of the next answer.
// Reset clears the configuration registers, the byte count and the flags.
// ============================================================================
module challenge_response_hash_top #(
    parameter int MAX_CHALLENGE_BYTES = chr_pkg::MAX_CHALLENGE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_challenge_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_hex_char,
    output logic        o_last_char,
    output logic        o_too_long,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);

    chr_pkg::t_cmd  cmd;
    chr_pkg::t_stat stat;

    chr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_is_last(i_is_last),
        .i_ready  (i_ready),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_ready  (o_ready),
        .o_valid  (o_valid)
    );

    chr_dp #(.MAX_CHALLENGE_BYTES(MAX_CHALLENGE_BYTES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_challenge_byte(i_challenge_byte),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_hex_char      (o_hex_char),
        .o_last_char     (o_last_char),
        .o_too_long      (o_too_long)
    );

endmodule

FILE: tb/tb.sv
// ============================================================================
// tb
// Challenge response hash testbench: drives challenge strings with random
// gaps, predicts each 32-digit answer (MD5 and mod 2^31-1 mixing) and
// checks every digit transfer in order.
// ============================================================================
class chr_scoreboard;
    typedef struct packed {
        logic [6:0] hex_char;
        logic       last_char;
        logic       too_long;
    } t_digit;

    logic [63:0] pid_first;
    logic [63:0] pid_last;
    logic [4:0]  pid_len;
    logic [7:0]  chal[$];
    logic        dropped;
    t_digit      answer_q[$];
    int          mismatches;

    function new();
        pid_first  = '0;
        pid_last   = '0;
        pid_len    = '0;
        dropped    = 1'b0;
        mismatches = 0;
    endfunction

    function automatic logic [31:0] rol(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void md5_digest(logic [7:0] msg[$], output logic [31:0] h[4]);
        logic [31:0] a, b, c, d, f, t, kk, w[16];
        logic [63:0] nbits;
        int g, r, ss;
        nbits = 64'(msg.size()) * 8;
        h[0] = 32'h67452301; h[1] = 32'hefcdab89;
        h[2] = 32'h98badcfe; h[3] = 32'h10325476;
        msg.push_back(chr_pkg::MD5_END);
        while (msg.size() % 64 != 56) msg.push_back(8'h00);
        for (int i = 0; i < 8; i++) msg.push_back(nbits[8*i +: 8]);
        for (int blk = 0; blk < msg.size(); blk += 64) begin
            for (int i = 0; i < 16; i++)
                w[i] = {msg[blk+4*i+3], msg[blk+4*i+2], msg[blk+4*i+1], msg[blk+4*i]};
            a = h[0]; b = h[1]; c = h[2]; d = h[3];
            for (int i = 0; i < 64; i++) begin
                r = i / 16;
                case (r)
                    0: begin f = (b & c) | (~b & d); g = i; end
                    1: begin f = (d & b) | (~d & c); g = (5*i + 1) % 16; end
                    2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
                    default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
                endcase
                kk = chr_pkg::md5_k(6'(i));
                case (r * 4 + i % 4)
                    0: ss = 7;  1: ss = 12; 2: ss = 17; 3: ss = 22;
                    4: ss = 5;  5: ss = 9;  6: ss = 14; 7: ss = 20;
                    8: ss = 4;  9: ss = 11; 10: ss = 16; 11: ss = 23;
                    12: ss = 6; 13: ss = 10; 14: ss = 15; default: ss = 21;
                endcase
                t = d; d = c; c = b;
                b = b + rol(a + f + kk + w[g], ss);
                a = t;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d;
        end
    endfunction

    function void note_byte(logic [7:0] ch, logic last);
        logic [7:0] msg[$];
        logic [31:0] dig[4], msk[4], word;
        logic [63:0] hi, lo, tt, c0, c1, m;
        logic [7:0] by;
        string kstr, hx;
        int plen, pad;
        if (chal.size() < chr_pkg::MAX_CHALLENGE_BYTES) chal.push_back(ch);
        else dropped = 1'b1;
        if (!last) return;
        kstr = "CFHUR$52U_{VIX5T";
        hx = "0123456789abcdef";
        msg = chal;
        for (int i = 0; i < 16; i++) msg.push_back(kstr[i]);
        md5_digest(msg, dig);
        for (int i = 0; i < 4; i++) msk[i] = dig[i] & 32'h7FFFFFFF;
        msg = chal;
        plen = (pid_len > 16) ? 16 : pid_len;
        for (int i = 0; i < plen; i++)
            msg.push_back(i < 8 ? pid_first[8*i +: 8] : pid_last[8*(i-8) +: 8]);
        pad = 8 - msg.size() % 8;
        for (int i = 0; i < pad; i++) msg.push_back(chr_pkg::PAD_CHAR);
        m = 64'h7FFFFFFF;
        hi = 0; lo = 0;
        for (int i = 0; i < msg.size(); i += 8) begin
            c0 = {32'h0, msg[i+3], msg[i+2], msg[i+1], msg[i]};
            c1 = {32'h0, msg[i+7], msg[i+6], msg[i+5], msg[i+4]};
            tt = (64'(msk[0]) * ((64'h0E79A9C1 * c0) % m + hi) + msk[1]) % m;
            hi = (64'(msk[2]) * ((c1 + tt) % m) + msk[3]) % m;
            lo = lo + hi + tt;
        end
        hi = (hi + msk[1]) % m;
        lo = (lo + msk[3]) % m;
        for (int i = 0; i < 16; i++) begin
            word = dig[i/4] ^ (((i/4) % 2) ? lo[31:0] : hi[31:0]);
            by = word[8*(i%4) +: 8];
            answer_q.push_back({7'(hx[by[7:4]]), 1'b0, dropped});
            answer_q.push_back({7'(hx[by[3:0]]), 1'(i == 15), dropped});
        end
        chal.delete();
        dropped = 1'b0;
    endfunction

    function void check_digit(t_digit got);
        t_digit exp_d;
        if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected digit %h", got);
            return;
        end
        exp_d = answer_q.pop_front();
        if (got !== exp_d) begin
            mismatches++;
            if (mismatches <= 10)
                $display("digit mismatch: exp char %h last %b long %b, got %h %b %b",
                    exp_d.hex_char, exp_d.last_char, exp_d.too_long,
                    got.hex_char, got.last_char, got.too_long);
        end
    endfunction
endclass

module tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_challenge_byte = 8'h01;
    logic        i_is_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [6:0]  o_hex_char;
    logic        o_last_char;
    logic        o_too_long;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = chr_pkg::CFG_PID_FIRST;
    logic [63:0] i_cfg_wdata = '0;

    chr_scoreboard answers = new();
    int  idle_cycles = 0;
    int  bytes_sent = 0;
    bit  calm = 1'b0;

    challenge_response_hash_top i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            answers.check_digit({o_hex_char, o_last_char, o_too_long});
        if (i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, none in the calm phase
    initial begin
        int n;
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            n = $urandom_range(1, 30);
            repeat (n) @(negedge i_clk);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            chr_pkg::CFG_PID_FIRST: answers.pid_first = val;
            chr_pkg::CFG_PID_LAST:  answers.pid_last = val;
            default:                answers.pid_len = val[4:0];
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] ch, logic last);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            n = $urandom_range(1, 18);
            repeat (n) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_challenge_byte <= ch;
        i_is_last <= last;
        do @(posedge i_clk); while (!o_ready);
        answers.note_byte(ch, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_challenge(int len, bit printable);
        for (int i = 0; i < len; i++)
            send_byte(printable ? 8'($urandom_range(33, 126)) : 8'($urandom_range(1, 255)),
                i == len - 1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (answers.answer_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_config();
        write_reg(chr_pkg::CFG_PID_FIRST, {$urandom, $urandom});
        write_reg(chr_pkg::CFG_PID_LAST, {$urandom, $urandom});
        write_reg(chr_pkg::CFG_PID_LEN, 64'($urandom_range(0, 31)));
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: single byte with empty product id, extremes of the byte
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b1);
        drain();
        write_reg(chr_pkg::CFG_PID_FIRST, 64'h3133_3030_3330_4F52);
        write_reg(chr_pkg::CFG_PID_LAST, '1);
        write_reg(chr_pkg::CFG_PID_LEN, 64'd16);
        send_challenge(22, 1'b1);
        drain();
        write_reg(chr_pkg::CFG_PID_FIRST, '0);
        write_reg(chr_pkg::CFG_PID_LEN, 64'd31);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        drain();

        // buffer overflow, then the flag clears
        write_reg(chr_pkg::CFG_PID_LEN, 64'd7);
        send_challenge(70, 1'b0);
        send_challenge(64, 1'b0);
        drain();

        // random phases with changing configuration
        while (bytes_sent < 480) begin
            random_config();
            for (int k = 0; k < 4 && bytes_sent < 480; k++) begin
                case ($urandom_range(0, 9))
                    0: send_challenge($urandom_range(60, 68), 1'b0);
                    1, 2: send_challenge($urandom_range(1, 8), 1'b0);
                    default: send_challenge($urandom_range(9, 40), $urandom_range(0, 1));
                endcase
                if (bytes_sent > 380) calm = 1'b1;
            end
            drain();
        end
        drain();
        repeat (20) @(negedge i_clk);
        if (answers.mismatches == 0 && answers.answer_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
